FILE: rtl/core/cws_pkg.sv
// ---------------------------------------------------------------------------
// cws_pkg
// Shared types and character codes for the comment and whitespace skipper.
// ---------------------------------------------------------------------------
package cws_pkg;

    // character codes
    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_FF    = 8'h0C;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_STAR  = 8'h2A;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;

    typedef enum logic [2:0] {
        MODE_IDLE       = 3'd0,
        MODE_PLAIN      = 3'd1,
        MODE_SLASH      = 3'd2,
        MODE_LINE       = 3'd3,
        MODE_BLOCK      = 3'd4,
        MODE_BLOCK_STAR = 3'd5
    } t_mode;

    typedef struct packed {
        logic [7:0]  text_byte;
        logic        run_start;
        logic [31:0] start_line;
        logic [15:0] start_column;
    } t_in_item;

    typedef struct packed {
        logic [15:0] skipped_bytes;
        logic [31:0] end_line;
        logic [15:0] end_column;
        logic        comment_unterminated;
    } t_out_item;

    // scanner status toward the handshake logic
    typedef struct packed {
        logic done;   // this byte ends the run
        logic idle;   // no run in progress
    } t_scan_status;

endpackage

FILE: rtl/core/cws_scan.sv
// ---------------------------------------------------------------------------
// cws_scan
// Per-byte scan state: mode, line, column and skip count. One byte per
// step; flags the byte that ends a run and forms the result.
// ---------------------------------------------------------------------------
module cws_scan #(
    parameter int COLUMN_BITS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  cws_pkg::t_in_item     i_item,
    output cws_pkg::t_scan_status o_status,
    output cws_pkg::t_out_item    o_result
);

    typedef enum logic [1:0] {
        ACT_NONE    = 2'd0,
        ACT_PLAIN   = 2'd1,
        ACT_PLAIN2  = 2'd2,
        ACT_NEWLINE = 2'd3
    } t_act;

    localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
    localparam logic [COUNT_BITS-1:0]  CNT_MAX  = '1;
    localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);

    cws_pkg::t_mode r_mode, n_mode, base_mode;
    logic [31:0]            r_line, n_line, base_line;
    logic [COLUMN_BITS-1:0] r_col, n_col, base_col, col_p1, col_p2;
    logic [COUNT_BITS-1:0]  r_cnt, n_cnt, base_cnt, cnt_p1, cnt_p2;
    logic [31:0]            start_col32;
    logic [31:0]            col32;
    logic [31:0]            cnt32;
    t_act                   act;
    logic                   done;
    logic                   open_comment;
    logic                   is_ws;
    logic [7:0]             c;

    assign c = i_item.text_byte;
    assign is_ws = (c == cws_pkg::CHAR_SPACE) || (c == cws_pkg::CHAR_TAB)
                || (c == cws_pkg::CHAR_FF) || (c == cws_pkg::CHAR_CR);

    // run start reloads position, clamping the column
    assign start_col32 = 32'(i_item.start_column);
    always_comb begin
        if (i_item.run_start) begin
            base_mode = cws_pkg::MODE_PLAIN;
            base_line = i_item.start_line;
            base_col  = (start_col32 > 32'(COL_MAX)) ? COL_MAX
                                                      : start_col32[COLUMN_BITS-1:0];
            base_cnt  = '0;
        end else begin
            base_mode = r_mode;
            base_line = r_line;
            base_col  = r_col;
            base_cnt  = r_cnt;
        end
    end

    // next mode and the counter action for this byte
    always_comb begin
        n_mode       = base_mode;
        act          = ACT_NONE;
        done         = 1'b0;
        open_comment = 1'b0;
        unique case (base_mode)
            cws_pkg::MODE_IDLE: begin
                n_mode = cws_pkg::MODE_IDLE;
            end
            cws_pkg::MODE_PLAIN: begin
                if (c == cws_pkg::CHAR_LF) begin
                    act = ACT_NEWLINE;
                end else if (is_ws) begin
                    act = ACT_PLAIN;
                end else if (c == cws_pkg::CHAR_SLASH) begin
                    n_mode = cws_pkg::MODE_SLASH;
                end else begin
                    done = 1'b1;   // NUL or significant byte
                end
            end
            cws_pkg::MODE_SLASH: begin
                if (c == cws_pkg::CHAR_SLASH) begin
                    act    = ACT_PLAIN2;
                    n_mode = cws_pkg::MODE_LINE;
                end else if (c == cws_pkg::CHAR_STAR) begin
                    act    = ACT_PLAIN2;
                    n_mode = cws_pkg::MODE_BLOCK;
                end else begin
                    done = 1'b1;   // the held slash is significant
                end
            end
            cws_pkg::MODE_LINE: begin
                if (c == cws_pkg::CHAR_NUL) begin
                    done         = 1'b1;
                    open_comment = 1'b1;
                end else if (c == cws_pkg::CHAR_LF) begin
                    act    = ACT_NEWLINE;
                    n_mode = cws_pkg::MODE_PLAIN;
                end else begin
                    act = ACT_PLAIN;
                end
            end
            cws_pkg::MODE_BLOCK, cws_pkg::MODE_BLOCK_STAR: begin
                if (c == cws_pkg::CHAR_NUL) begin
                    done         = 1'b1;
                    open_comment = 1'b1;
                end else if (c == cws_pkg::CHAR_LF) begin
                    act    = ACT_NEWLINE;
                    n_mode = cws_pkg::MODE_BLOCK;
                end else begin
                    act = ACT_PLAIN;
                    if (c == cws_pkg::CHAR_STAR) begin
                        n_mode = cws_pkg::MODE_BLOCK_STAR;
                    end else if (c == cws_pkg::CHAR_SLASH
                                 && base_mode == cws_pkg::MODE_BLOCK_STAR) begin
                        n_mode = cws_pkg::MODE_PLAIN;
                    end else begin
                        n_mode = cws_pkg::MODE_BLOCK;
                    end
                end
            end
            default: begin
                n_mode = cws_pkg::MODE_IDLE;
            end
        endcase
        if (done) begin
            n_mode = cws_pkg::MODE_IDLE;
        end
    end

    // saturating increments
    assign col_p1 = (base_col == COL_MAX) ? base_col : base_col + COL_ONE;
    assign col_p2 = (col_p1 == COL_MAX) ? col_p1 : col_p1 + COL_ONE;
    assign cnt_p1 = (base_cnt == CNT_MAX) ? base_cnt : base_cnt + COUNT_BITS'(1);
    assign cnt_p2 = (cnt_p1 == CNT_MAX) ? cnt_p1 : cnt_p1 + COUNT_BITS'(1);

    always_comb begin
        n_line = base_line;
        n_col  = base_col;
        n_cnt  = base_cnt;
        case (act)
            ACT_PLAIN: begin
                n_col = col_p1;
                n_cnt = cnt_p1;
            end
            ACT_PLAIN2: begin
                n_col = col_p2;
                n_cnt = cnt_p2;
            end
            ACT_NEWLINE: begin
                n_line = (base_line == 32'hFFFF_FFFF) ? base_line : base_line + 32'd1;
                n_col  = COL_ONE;
                n_cnt  = cnt_p1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= cws_pkg::MODE_IDLE;
            r_line <= '0;
            r_col  <= '0;
            r_cnt  <= '0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_line <= n_line;
            r_col  <= n_col;
            r_cnt  <= n_cnt;
        end
    end

    // result is the position before this byte
    assign col32 = 32'(base_col);
    assign cnt32 = 32'(base_cnt);

    assign o_result.skipped_bytes        = cnt32[15:0];
    assign o_result.end_line             = base_line;
    assign o_result.end_column           = col32[15:0];
    assign o_result.comment_unterminated = open_comment;

    assign o_status.done = done;
    assign o_status.idle = (r_mode == cws_pkg::MODE_IDLE);

endmodule

FILE: rtl/core/comment_whitespace_skipper_core.sv
// ---------------------------------------------------------------------------
// comment_whitespace_skipper_core
// Skips white space and C-style comments in a byte stream and reports the
// skip count and the position of the first significant character or of the NUL.
// ---------------------------------------------------------------------------
// Takes one text byte per clock unless the input stalls. A byte is held in
// the input register while the scan state (mode, line, column, count)
// advances on it; when the scanner steps on a byte that ends a run, the
// run's result is loaded into the output register and o_out_valid rises.
// Throughput is one byte per clock while the input is not stalled. The input
// stalls only when a byte would end a run while the previous result is still
// held by a stalled output.
module comment_whitespace_skipper_core #(
    parameter int COLUMN_BITS = 16,
    parameter int COUNT_BITS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  cws_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output cws_pkg::t_out_item o_out_data
);

    logic                  r_in_valid;
    cws_pkg::t_in_item     r_in;
    logic                  r_out_valid;
    cws_pkg::t_out_item    r_out;
    cws_pkg::t_scan_status status;
    cws_pkg::t_out_item    result;
    logic                  out_blocked;
    logic                  step;
    logic                  in_xfer;

    cws_scan #(
        .COLUMN_BITS (COLUMN_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in),
        .o_status (status),
        .o_result (result)
    );

    assign out_blocked = r_out_valid && i_out_stall;
    assign step        = r_in_valid && !(status.done && out_blocked);
    assign o_in_stall  = r_in_valid && !step;
    assign in_xfer     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && status.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && status.done) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // a finished run always lands in the output register
    a_done_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && status.done |=> o_out_valid)
        else $error("finished run did not reach output");

    // scanner returns to idle after a run ends
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && status.done |=> status.idle)
        else $error("scanner not idle after run end");

    // input stalls only behind a held byte that cannot move
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && status.done && out_blocked)
        else $error("input stalled without cause");

endmodule

FILE: test/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for comment_whitespace_skipper_core. A directed table
// hits saturation, comments cut off by end of text, a lone slash and
// restarts. Then come a held-off output and random text runs. Table stops
// are checked against typed values, the rest against an in-bench scanner model.
// ---------------------------------------------------------------------------
module tb_top;
    import cws_pkg::*;

    localparam int STUCK_LIMIT  = 2000;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_BYTES = 1530;
    localparam int CALM_BYTES   = 200;
    localparam int TAIL_CYCLES  = 10;

    typedef struct packed {
        t_in_item  stim;
        logic      typed;
        t_out_item want;
    } t_stim_row;

    localparam logic [65:0] NO_STOP = '0;

    logic      clk      = 1'b0;
    logic      rst_n    = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_data  = '0;
    logic      out_stall = 1'b0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;

    // scanner model state
    t_mode       p_mode  = MODE_IDLE;
    logic [31:0] p_line  = '0;
    logic [15:0] p_col   = '0;
    logic [15:0] p_skips = '0;

    t_out_item   pending_stops[$];
    logic [7:0]  text_q[$];

    int  mismatch_count = 0;
    int  stops_checked  = 0;
    int  bytes_sent     = 0;
    int  runs_sent      = 0;
    int  quiet_cycles   = 0;
    bit  hold_request   = 1'b0;
    bit  tail_calm      = 1'b0;
    bit  gaps_on        = 1'b1;

    // byte, run_start, start line, start column | typed, skipped, line, column, open
    t_stim_row directed_rows [27] = '{
        {CHAR_SPACE, 1'b0, 32'd0, 16'd0, NO_STOP},                  // ignored while idle
        {8'h61, 1'b1, 32'd0, 16'd0, 1'b1, 16'd0, 32'd0, 16'd0, 1'b0},
        {CHAR_LF, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, NO_STOP},          // line saturates
        {CHAR_NUL, 1'b0, 32'd0, 16'd0, 1'b1, 16'd1, 32'hFFFF_FFFF, 16'd1, 1'b0},
        {CHAR_TAB, 1'b1, 32'd5, 16'hFFFF, NO_STOP},                 // column saturates
        {8'h78, 1'b0, 32'd0, 16'd0, 1'b1, 16'd1, 32'd5, 16'hFFFF, 1'b0},
        {CHAR_SLASH, 1'b1, 32'd1, 16'd1, NO_STOP},                  // slash, then other
        {8'h71, 1'b0, 32'd0, 16'd0, 1'b1, 16'd0, 32'd1, 16'd1, 1'b0},
        {CHAR_SLASH, 1'b1, 32'd2, 16'd3, NO_STOP},                  // slash, then NUL
        {CHAR_NUL, 1'b0, 32'd0, 16'd0, 1'b1, 16'd0, 32'd2, 16'd3, 1'b0},
        {CHAR_SLASH, 1'b1, 32'd0, 16'd0, NO_STOP},                  // open line comment
        {CHAR_SLASH, 1'b0, 32'd0, 16'd0, NO_STOP},
        {8'h61, 1'b0, 32'd0, 16'd0, NO_STOP},
        {CHAR_NUL, 1'b0, 32'd0, 16'd0, 1'b1, 16'd3, 32'd0, 16'd3, 1'b1},
        {CHAR_SLASH, 1'b1, 32'd7, 16'd1, NO_STOP},                  // open block comment
        {CHAR_STAR, 1'b0, 32'd0, 16'd0, NO_STOP},
        {CHAR_LF, 1'b0, 32'd0, 16'd0, NO_STOP},
        {CHAR_STAR, 1'b0, 32'd0, 16'd0, NO_STOP},
        {CHAR_NUL, 1'b0, 32'd0, 16'd0, 1'b1, 16'd4, 32'd8, 16'd2, 1'b1},
        {CHAR_CR, 1'b1, 32'd1, 16'd1, NO_STOP},                     // restart mid-run
        {CHAR_FF, 1'b1, 32'd10, 16'd20, NO_STOP},
        {8'h7D, 1'b0, 32'd0, 16'd0, 1'b1, 16'd1, 32'd10, 16'd21, 1'b0},
        {CHAR_SLASH, 1'b1, 32'd3, 16'd1, NO_STOP},                  // closed block comment
        {CHAR_STAR, 1'b0, 32'd0, 16'd0, NO_STOP},
        {CHAR_STAR, 1'b0, 32'd0, 16'd0, NO_STOP},
        {CHAR_SLASH, 1'b0, 32'd0, 16'd0, NO_STOP},
        {8'hFF, 1'b0, 32'd0, 16'd0, 1'b1, 16'd4, 32'd3, 16'd5, 1'b0}
    };

    comment_whitespace_skipper_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // ---------------- scanner model ----------------
    task take_byte();
        if (p_col != '1) p_col++;
        if (p_skips != '1) p_skips++;
    endtask

    task take_newline();
        if (p_line != '1) p_line++;
        p_col = 16'd1;
        if (p_skips != '1) p_skips++;
    endtask

    task automatic advance_scan(input t_in_item it, output bit stops, output t_out_item stop);
        logic [7:0] c;
        logic       open;
        c     = it.text_byte;
        stops = 1'b0;
        open  = 1'b0;
        stop  = '0;
        if (it.run_start) begin
            p_line  = it.start_line;
            p_col   = it.start_column;
            p_skips = '0;
            p_mode  = MODE_PLAIN;
        end
        case (p_mode)
            MODE_PLAIN: begin
                if (c == CHAR_NUL) stops = 1'b1;
                else if (c == CHAR_LF) take_newline();
                else if (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_FF || c == CHAR_CR)
                    take_byte();
                else if (c == CHAR_SLASH) p_mode = MODE_SLASH;
                else stops = 1'b1;
            end
            MODE_SLASH: begin
                // the lookahead byte is dropped when it opens no comment
                if (c == CHAR_SLASH || c == CHAR_STAR) begin
                    take_byte();
                    take_byte();
                    p_mode = (c == CHAR_SLASH) ? MODE_LINE : MODE_BLOCK;
                end else begin
                    stops = 1'b1;
                end
            end
            MODE_LINE: begin
                if (c == CHAR_NUL) begin
                    stops = 1'b1;
                    open  = 1'b1;
                end else if (c == CHAR_LF) begin
                    take_newline();
                    p_mode = MODE_PLAIN;
                end else begin
                    take_byte();
                end
            end
            MODE_BLOCK, MODE_BLOCK_STAR: begin
                if (c == CHAR_NUL) begin
                    stops = 1'b1;
                    open  = 1'b1;
                end else if (c == CHAR_LF) begin
                    take_newline();
                    p_mode = MODE_BLOCK;
                end else begin
                    take_byte();
                    if (c == CHAR_STAR) p_mode = MODE_BLOCK_STAR;
                    else if (c == CHAR_SLASH && p_mode == MODE_BLOCK_STAR) p_mode = MODE_PLAIN;
                    else p_mode = MODE_BLOCK;
                end
            end
            default: p_mode = MODE_IDLE;
        endcase
        if (stops) begin
            stop.skipped_bytes        = p_skips;
            stop.end_line             = p_line;
            stop.end_column           = p_col;
            stop.comment_unterminated = open;
            p_mode = MODE_IDLE;
        end
    endtask

    // ---------------- text generation ----------------
    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0: return CHAR_SPACE;
            1: return CHAR_TAB;
            2: return CHAR_FF;
            default: return CHAR_CR;
        endcase
    endfunction

    function automatic logic [7:0] pick_significant();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255));
        while (c == CHAR_TAB || c == CHAR_LF || c == CHAR_FF || c == CHAR_CR ||
               c == CHAR_SPACE || c == CHAR_SLASH);
        return c;
    endfunction

    task automatic add_comment_body(input bit in_block);
        logic [7:0] c;
        logic [7:0] last;
        last = CHAR_SPACE;
        repeat ($urandom_range(0, 8)) begin
            case ($urandom_range(0, 9))
                0: c = CHAR_STAR;
                1: c = CHAR_SLASH;
                2: c = CHAR_SPACE;
                3: c = CHAR_LF;
                default: c = 8'($urandom_range(1, 255));
            endcase
            if (!in_block && c == CHAR_LF) c = 8'h62;
            // keep block comments from closing early
            if (in_block && c == CHAR_SLASH && last == CHAR_STAR) c = 8'h63;
            text_q.push_back(c);
            last = c;
        end
    endtask

    task automatic build_run();
        logic [7:0] c;
        text_q.delete();
        repeat ($urandom_range(0, 6)) begin
            case ($urandom_range(0, 4))
                0, 1: repeat ($urandom_range(1, 3)) text_q.push_back(pick_blank());
                2: text_q.push_back(CHAR_LF);
                3: begin
                    text_q.push_back(CHAR_SLASH);
                    text_q.push_back(CHAR_SLASH);
                    add_comment_body(1'b0);
                    text_q.push_back(CHAR_LF);
                end
                default: begin
                    text_q.push_back(CHAR_SLASH);
                    text_q.push_back(CHAR_STAR);
                    add_comment_body(1'b1);
                    text_q.push_back(CHAR_STAR);
                    text_q.push_back(CHAR_SLASH);
                end
            endcase
        end
        case ($urandom_range(0, 9))
            0, 1, 2, 3: text_q.push_back(pick_significant());
            4, 5: begin
                do c = 8'($urandom_range(0, 255));
                while (c == CHAR_SLASH || c == CHAR_STAR);
                text_q.push_back(CHAR_SLASH);
                text_q.push_back(c);
            end
            6: text_q.push_back(CHAR_NUL);
            7: begin
                text_q.push_back(CHAR_SLASH);
                text_q.push_back(CHAR_SLASH);
                add_comment_body(1'b0);
                text_q.push_back(CHAR_NUL);
            end
            default: begin
                text_q.push_back(CHAR_SLASH);
                text_q.push_back(CHAR_STAR);
                add_comment_body(1'b1);
                text_q.push_back(CHAR_NUL);
            end
        endcase
        // broken run: cut short, the next run start abandons it
        if (text_q.size() > 1 && $urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, text_q.size() - 1)) void'(text_q.pop_back());
    endtask

    // ---------------- input side ----------------
    task automatic drive_byte(input t_in_item it, input bit typed, input t_out_item want);
        bit        taken;
        bit        stops;
        t_out_item stop;
        if (gaps_on && !tail_calm && $urandom_range(0, 11) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_data  <= it;
        in_valid <= 1'b1;
        do begin
            @(negedge clk);
            taken = !o_in_stall;
            @(posedge clk);
        end while (!taken);
        advance_scan(it, stops, stop);
        if (typed) pending_stops.push_back(want);
        else if (stops) pending_stops.push_back(stop);
        bytes_sent++;
    endtask

    task automatic send_text(input bit fresh);
        t_in_item it;
        foreach (text_q[i]) begin
            it.text_byte    = text_q[i];
            it.run_start    = fresh && (i == 0);
            it.start_line   = $urandom;
            it.start_column = 16'($urandom);
            if (it.run_start && $urandom_range(0, 7) == 0)
                it.start_line = 32'hFFFF_FFFF - $urandom_range(0, 2);
            if (it.run_start && $urandom_range(0, 7) == 0)
                it.start_column = 16'hFFFF - 16'($urandom_range(0, 2));
            drive_byte(it, 1'b0, '0);
        end
        runs_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        wait (pending_stops.size() == 0);
        @(posedge clk);
    endtask

    // ---------------- output side ----------------
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && !tail_calm && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 19);
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    // sample at the falling edge: the transfer happens at the next rising edge
    always @(negedge clk) begin
        t_out_item want;
        if (rst_n && o_out_valid && !out_stall) begin
            if (pending_stops.size() == 0) begin
                $error("stop report with none pending: skipped %0d line %0d column %0d",
                       o_out_data.skipped_bytes, o_out_data.end_line, o_out_data.end_column);
                mismatch_count++;
            end else begin
                want = pending_stops.pop_front();
                check_field("skipped_bytes", 32'(want.skipped_bytes),
                            32'(o_out_data.skipped_bytes));
                check_field("end_line", want.end_line, o_out_data.end_line);
                check_field("end_column", 32'(want.end_column), 32'(o_out_data.end_column));
                check_field("comment_unterminated", 32'(want.comment_unterminated),
                            32'(o_out_data.comment_unterminated));
                stops_checked++;
            end
        end
    end

    always @(negedge clk) begin
        if (!rst_n || (in_valid && !o_in_stall) || (o_out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STUCK_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ---------------- main sequence ----------------
    initial begin
        t_in_item it;
        int       random_start;
        bit       mid_pause_done;
        mid_pause_done = 1'b0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r])
            drive_byte(directed_rows[r].stim, directed_rows[r].typed, directed_rows[r].want);
        wait_drained();

        // output held off while short runs keep coming: the block must back up
        hold_request = 1'b1;
        gaps_on = 1'b0;
        repeat (40) begin
            it.text_byte    = pick_significant();
            it.run_start    = 1'b1;
            it.start_line   = $urandom;
            it.start_column = 16'($urandom);
            drive_byte(it, 1'b0, '0);
        end
        gaps_on = 1'b1;
        wait_drained();

        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            if (bytes_sent - random_start >= RANDOM_BYTES - CALM_BYTES) tail_calm = 1'b1;
            if (!mid_pause_done && bytes_sent - random_start >= RANDOM_BYTES / 2) begin
                wait_drained();
                mid_pause_done = 1'b1;
            end
            if ($urandom_range(0, 9) == 0) begin
                // noise: random bytes with stray run starts
                repeat ($urandom_range(1, 8)) begin
                    it.text_byte    = 8'($urandom);
                    it.run_start    = ($urandom_range(0, 3) == 0);
                    it.start_line   = $urandom;
                    it.start_column = 16'($urandom);
                    drive_byte(it, 1'b0, '0);
                end
            end else begin
                build_run();
                send_text(1'b1);
            end
        end

        in_valid <= 1'b0;
        wait (pending_stops.size() == 0);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d bytes: directed table, %0d-cycle output hold, then generated text",
                 bytes_sent, LONG_HOLD);
        $display("in %0d runs with noise bursts; %0d stop reports compared.", runs_sent,
                 stops_checked);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
